### rtl/core/gpio_pkg.sv
// Package for the GPIO port: widths, operation and register codes,
// interrupt sense codes and the result record.
// No dependencies; every other file in rtl/core uses it by scoped names.
package gpio_pkg;

  localparam int WORD_W = 32;
  localparam int HALF_W = 16;
  localparam int CODE_W = 2;
  localparam int OP_W   = 2;
  localparam int SEL_W  = 3;

  // Transaction kinds
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

  // Register map
  localparam logic [SEL_W-1:0] REG_DATA     = 3'd0;
  localparam logic [SEL_W-1:0] REG_DIR      = 3'd1;
  localparam logic [SEL_W-1:0] REG_ICR_LOW  = 3'd2;
  localparam logic [SEL_W-1:0] REG_ICR_HIGH = 3'd3;
  localparam logic [SEL_W-1:0] REG_MASK     = 3'd4;
  localparam logic [SEL_W-1:0] REG_STATUS   = 3'd5;
  localparam logic [SEL_W-1:0] REG_ANY_EDGE = 3'd6;

  // Interrupt sense codes
  localparam logic [CODE_W-1:0] ICR_LOW_LEVEL  = 2'd0;
  localparam logic [CODE_W-1:0] ICR_HIGH_LEVEL = 2'd1;
  localparam logic [CODE_W-1:0] ICR_RISE       = 2'd2;
  localparam logic [CODE_W-1:0] ICR_FALL       = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] pad_out;
    logic [WORD_W-1:0] pad_drive_enable;
    logic              irq_low_pins;
    logic              irq_high_pins;
  } result_t;

endpackage

### rtl/core/gpio_if.sv
// Handshake channels of the GPIO port: request side and result side.
// Depends on gpio_pkg for field widths.
interface gpio_req_if;
  logic                          valid;
  logic                          ready;
  logic [gpio_pkg::OP_W-1:0]     operation;
  logic [gpio_pkg::SEL_W-1:0]    reg_select;
  logic [gpio_pkg::WORD_W-1:0]   write_data;
  logic [gpio_pkg::WORD_W-1:0]   pad_in;

  modport source (output valid, operation, reg_select, write_data, pad_in, input ready);
  modport sink   (input valid, operation, reg_select, write_data, pad_in, output ready);
endinterface

interface gpio_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gpio_pkg::WORD_W-1:0]   read_data;
  logic [gpio_pkg::WORD_W-1:0]   pad_out;
  logic [gpio_pkg::WORD_W-1:0]   pad_drive_enable;
  logic                          irq_low_pins;
  logic                          irq_high_pins;

  modport source (output valid, read_data, pad_out, pad_drive_enable, irq_low_pins,
                  irq_high_pins, input ready);
  modport sink   (input valid, read_data, pad_out, pad_drive_enable, irq_low_pins,
                  irq_high_pins, output ready);
endinterface

### rtl/core/gpio_lane.sv
// One pin's interrupt condition detector.
// Depends on gpio_pkg for the sense codes.
module gpio_lane (
  input  logic                           now,
  input  logic                           was,
  input  logic [gpio_pkg::CODE_W-1:0]    code,
  input  logic                           any_edge,
  output logic                           hit
);

  logic sense_hit;

  // Decode the configured sense
  always_comb begin
    unique case (code)
      gpio_pkg::ICR_LOW_LEVEL:  sense_hit = ~now;
      gpio_pkg::ICR_HIGH_LEVEL: sense_hit = now;
      gpio_pkg::ICR_RISE:       sense_hit = now & ~was;
      gpio_pkg::ICR_FALL:       sense_hit = was & ~now;
      default:                  sense_hit = 1'b0;
    endcase
  end

  // Any-edge select overrides the code
  assign hit = any_edge ? (now ^ was) : sense_hit;

endmodule

### rtl/core/gpio_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
// Depends on gpio_pkg (result_t) and gpio_rsp_if.
module gpio_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  gpio_pkg::result_t  push_data,
  gpio_rsp_if.source         rsp
);

  logic               main_valid;
  gpio_pkg::result_t  main_data;
  logic               skid_valid;
  gpio_pkg::result_t  skid_data;
  logic               push;
  logic               drain;

  assign push_ready = ~skid_valid;
  assign push       = push_valid & push_ready;
  assign drain      = main_valid & rsp.ready;

  // Refill the output register from skid first, then from the new transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain || !main_valid) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

  assign rsp.valid            = main_valid;
  assign rsp.read_data        = main_data.read_data;
  assign rsp.pad_out          = main_data.pad_out;
  assign rsp.pad_drive_enable = main_data.pad_drive_enable;
  assign rsp.irq_low_pins     = main_data.irq_low_pins;
  assign rsp.irq_high_pins    = main_data.irq_high_pins;

  // Skid holds a result only behind an occupied output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid) else $error("skid occupied with empty output register");

  // A parked result stays until the output register drains
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !drain) |=> skid_valid) else $error("skid result lost");

  // A result accepted into a full, stalled buffer lands in skid
  a_push_parks: assert property (@(posedge clk) disable iff (rst)
    (push && main_valid && !drain) |=> skid_valid) else $error("result dropped");

endmodule

### rtl/core/gpio_port_with_interrupt_detect_unit.sv
// Top level of the 32-pin GPIO port with per-pin interrupt detection.
// Depends on gpio_pkg, gpio_if (gpio_req_if, gpio_rsp_if), gpio_lane, gpio_out_buf.
//
//  channel | dir | payload                                              | ready
//  req     | in  | operation, reg_select, write_data, pad_in            | buffer has room
//  rsp     | out | read_data, pad_out, pad_drive_enable, irq_low/high   | from consumer
//
// One transaction per clock while the buffer has room: registers, pad history and
// status update at the accepting edge; the result is registered into the output buffer.
// Each pin has its own detector lane; the lanes' hits merge into the status word.
// Reset (synchronous) clears all registers and the pad history.
// A stalled result waits in a two-entry buffer; req stalls only when both are full.
module gpio_port_with_interrupt_detect_unit #(
  parameter int PIN_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst,
  gpio_req_if.sink   req,
  gpio_rsp_if.source rsp
);

  localparam int W = gpio_pkg::WORD_W;
  localparam int H = gpio_pkg::HALF_W;
  localparam int C = gpio_pkg::CODE_W;
  localparam logic [W-1:0] PIN_MASK = {W{1'b1}} >> (W - PIN_COUNT);

  logic [W-1:0] data_reg,      data_reg_next;
  logic [W-1:0] direction_reg, direction_reg_next;
  logic [W-1:0] int_cfg_low,   int_cfg_low_next;
  logic [W-1:0] int_cfg_high,  int_cfg_high_next;
  logic [W-1:0] int_mask,      int_mask_next;
  logic [W-1:0] int_status,    int_status_next;
  logic [W-1:0] any_edge_sel,  any_edge_sel_next;
  logic [W-1:0] prev_pads;

  logic [W-1:0]      pads;
  logic [W-1:0]      hits;
  logic [W-1:0]      clr;
  logic [W-1:0]      rd;
  logic [W-1:0]      active;
  logic              accept;
  logic              is_write;
  logic              buf_ready;
  gpio_pkg::result_t result;

  assign accept = req.valid & buf_ready;
  assign req.ready = buf_ready;
  assign pads = req.pad_in & PIN_MASK;
  assign is_write = (req.operation == gpio_pkg::OP_WRITE);

  // Detector lanes, one per existing pin
  for (genvar i = 0; i < W; i++) begin : g_lane
    if (i < PIN_COUNT) begin : g_pin
      logic [C-1:0] code;
      if (i < H) begin : g_lo
        assign code = int_cfg_low[C*i +: C];
      end else begin : g_hi
        assign code = int_cfg_high[C*(i-H) +: C];
      end
      gpio_lane u_lane (
        .now      (pads[i]),
        .was      (prev_pads[i]),
        .code     (code),
        .any_edge (any_edge_sel[i]),
        .hit      (hits[i])
      );
    end else begin : g_none
      assign hits[i] = 1'b0;
    end
  end

  // Register read, from the state before this transaction
  always_comb begin
    rd = '0;
    if (req.operation == gpio_pkg::OP_READ) begin
      unique case (req.reg_select)
        gpio_pkg::REG_DATA:     rd = (pads & ~direction_reg) | (data_reg & direction_reg);
        gpio_pkg::REG_DIR:      rd = direction_reg;
        gpio_pkg::REG_ICR_LOW:  rd = int_cfg_low;
        gpio_pkg::REG_ICR_HIGH: rd = int_cfg_high;
        gpio_pkg::REG_MASK:     rd = int_mask;
        gpio_pkg::REG_STATUS:   rd = int_status;
        gpio_pkg::REG_ANY_EDGE: rd = any_edge_sel;
        default:                rd = '0;
      endcase
    end
  end

  // Register write and status merge
  always_comb begin
    data_reg_next      = data_reg;
    direction_reg_next = direction_reg;
    int_cfg_low_next   = int_cfg_low;
    int_cfg_high_next  = int_cfg_high;
    int_mask_next      = int_mask;
    any_edge_sel_next  = any_edge_sel;
    clr                = '0;
    if (is_write) begin
      unique case (req.reg_select)
        gpio_pkg::REG_DATA:     data_reg_next      = req.write_data & PIN_MASK;
        gpio_pkg::REG_DIR:      direction_reg_next = req.write_data & PIN_MASK;
        gpio_pkg::REG_ICR_LOW:  int_cfg_low_next   = req.write_data;
        gpio_pkg::REG_ICR_HIGH: int_cfg_high_next  = req.write_data;
        gpio_pkg::REG_MASK:     int_mask_next      = req.write_data & PIN_MASK;
        gpio_pkg::REG_STATUS:   clr                = req.write_data & PIN_MASK;
        gpio_pkg::REG_ANY_EDGE: any_edge_sel_next  = req.write_data & PIN_MASK;
        default:                clr                = '0;
      endcase
    end
    // A condition met in the same cycle as a clear wins
    int_status_next = ((int_status & ~clr) | hits) & PIN_MASK;
  end

  // Merge lane results into the two interrupt lines
  assign active = int_status_next & int_mask_next;

  always_comb begin
    result.read_data        = rd;
    result.pad_out          = data_reg_next;
    result.pad_drive_enable = direction_reg_next;
    result.irq_low_pins     = |active[H-1:0];
    result.irq_high_pins    = |active[W-1:H];
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      data_reg      <= '0;
      direction_reg <= '0;
      int_cfg_low   <= '0;
      int_cfg_high  <= '0;
      int_mask      <= '0;
      int_status    <= '0;
      any_edge_sel  <= '0;
      prev_pads     <= '0;
    end else if (accept) begin
      data_reg      <= data_reg_next;
      direction_reg <= direction_reg_next;
      int_cfg_low   <= int_cfg_low_next;
      int_cfg_high  <= int_cfg_high_next;
      int_mask      <= int_mask_next;
      int_status    <= int_status_next;
      any_edge_sel  <= any_edge_sel_next;
      prev_pads     <= pads;
    end
  end

  gpio_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req.valid),
    .push_ready (buf_ready),
    .push_data  (result),
    .rsp        (rsp)
  );

  // Missing pins never raise status
  a_status_in_range: assert property (@(posedge clk) disable iff (rst)
    (int_status & ~PIN_MASK) == '0) else $error("status bit set on missing pin");

  // State holds while no transaction is accepted
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(int_status) && $stable(prev_pads) && $stable(data_reg)))
    else $error("state changed without a transaction");

  // A status write of all ones with no new condition leaves status clear
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && is_write && req.reg_select == gpio_pkg::REG_STATUS &&
     req.write_data == '1 && hits == '0) |=> (int_status == '0))
    else $error("status clear failed");

endmodule
